// ===== sv/o4wsm_pkg.sv =====
// Shared types and constants for the four-wheel omni speed mixer.
// Used by omni4_wheel_speed_mixer; depends on nothing else.
package o4wsm_pkg;

    localparam int DEFAULT_FRACTION_BITS = 12;

    // widths of the request/result fields and the config registers
    localparam int FIELD_W = 16;
    localparam int SPEED_W = 15;
    localparam int ARM_W   = 14;

    // 1/sqrt2 in Q30
    localparam int                  INV_SQRT2_SHIFT = 30;
    localparam logic [INV_SQRT2_SHIFT-1:0] INV_SQRT2_Q30 = 30'd759250125;

    // scale factor k = limit * 2^SCALE_BITS / peak
    localparam int SCALE_BITS = 16;

    // register map, indexed by paddr[3:2]
    localparam int REG_ADDR_W = 4;
    localparam logic [1:0] REG_MAX_SIDEWAYS = 2'd0;
    localparam logic [1:0] REG_MAX_FORWARD  = 2'd1;
    localparam logic [1:0] REG_MAX_WHEEL    = 2'd2;
    localparam logic [1:0] REG_ARM_LENGTH   = 2'd3;

    localparam logic [SPEED_W-1:0] RST_MAX_SIDEWAYS = 15'd8192;
    localparam logic [SPEED_W-1:0] RST_MAX_FORWARD  = 15'd8192;
    localparam logic [SPEED_W-1:0] RST_MAX_WHEEL    = 15'd16384;
    localparam logic [ARM_W-1:0]   RST_ARM_LENGTH   = 14'd2027;

    typedef struct packed {
        logic signed [FIELD_W-1:0] sideways_request;
        logic signed [FIELD_W-1:0] forward_request;
        logic signed [FIELD_W-1:0] turn_request;
    } request_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] wheel_a_speed;
        logic signed [FIELD_W-1:0] wheel_b_speed;
        logic signed [FIELD_W-1:0] wheel_c_speed;
        logic signed [FIELD_W-1:0] wheel_d_speed;
        logic                      was_scaled;
    } result_t;

endpackage

// ===== sv/omni4_wheel_speed_mixer.sv =====
// Top level of the four-wheel omni speed mixer: clamp, 1/sqrt2 and turn products,
// wheel sums, peak search, pipelined divider for the scale factor, final scaling.
// Depends on o4wsm_pkg.
//
// Usage: raise start with a request on any cycle; busy is always low, so every
// request is taken at once, one per clock if wanted. Each request yields exactly
// one result, shown on result for a single cycle with done high. The receiver
// cannot stall the block and needs none: results leave in request order at the
// rate they came in. Each request passes through the 16-stage restoring
// divider (one quotient bit per stage) that forms limit/peak, plus four stages
// ahead of it (clamp, products, wheel sums, peak) and two after it (scaling
// product, saturate). Write the configuration registers over the APB port only
// while no request is in flight; pready is tied high.
module omni4_wheel_speed_mixer #(
    parameter int FRACTION_BITS = o4wsm_pkg::DEFAULT_FRACTION_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // request side
    input  logic                                   start,
    output logic                                   busy,
    input  o4wsm_pkg::request_t                    request,
    // result side
    output logic                                   done,
    output o4wsm_pkg::result_t                     result,
    // configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [o4wsm_pkg::REG_ADDR_W-1:0]       paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    localparam int FW     = o4wsm_pkg::FIELD_W;
    localparam int SW     = o4wsm_pkg::SPEED_W;
    localparam int AW     = o4wsm_pkg::ARM_W;
    localparam int CSH    = o4wsm_pkg::INV_SQRT2_SHIFT;
    localparam int KB     = o4wsm_pkg::SCALE_BITS;
    // 1/sqrt2 product: signed speed times the Q30 constant
    localparam int CPW    = FW + CSH + 1;
    // turn product: signed request times zero-extended arm length
    localparam int TPW    = FW + AW + 1;
    localparam int TW     = TPW - FRACTION_BITS;
    // wheel sums need two bits over the widest term
    localparam int WW     = ((TW > FW) ? TW : FW) + 2;
    localparam int PW     = WW + KB + 1;
    localparam int DIV_STEPS = KB;

    localparam logic signed [WW:0] SAT_HI = {{(WW-FW+2){1'b0}}, {(FW-1){1'b1}}};
    localparam logic signed [WW:0] SAT_LO = {{(WW-FW+2){1'b1}}, {(FW-1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SW-1:0] max_sideways_reg, max_sideways_next;
    logic [SW-1:0] max_forward_reg,  max_forward_next;
    logic [SW-1:0] max_wheel_reg,    max_wheel_next;
    logic [AW-1:0] arm_length_reg,   arm_length_next;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        max_sideways_next = max_sideways_reg;
        max_forward_next  = max_forward_reg;
        max_wheel_next    = max_wheel_reg;
        arm_length_next   = arm_length_reg;
        if (cfg_wr)
        begin
            case (paddr[3:2])
                o4wsm_pkg::REG_MAX_SIDEWAYS: max_sideways_next = pwdata[SW-1:0];
                o4wsm_pkg::REG_MAX_FORWARD:  max_forward_next  = pwdata[SW-1:0];
                o4wsm_pkg::REG_MAX_WHEEL:    max_wheel_next    = pwdata[SW-1:0];
                o4wsm_pkg::REG_ARM_LENGTH:   arm_length_next   = pwdata[AW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            o4wsm_pkg::REG_MAX_SIDEWAYS: prdata = {{(32-SW){1'b0}}, max_sideways_reg};
            o4wsm_pkg::REG_MAX_FORWARD:  prdata = {{(32-SW){1'b0}}, max_forward_reg};
            o4wsm_pkg::REG_MAX_WHEEL:    prdata = {{(32-SW){1'b0}}, max_wheel_reg};
            o4wsm_pkg::REG_ARM_LENGTH:   prdata = {{(32-AW){1'b0}}, arm_length_reg};
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_sideways_reg <= o4wsm_pkg::RST_MAX_SIDEWAYS;
            max_forward_reg  <= o4wsm_pkg::RST_MAX_FORWARD;
            max_wheel_reg    <= o4wsm_pkg::RST_MAX_WHEEL;
            arm_length_reg   <= o4wsm_pkg::RST_ARM_LENGTH;
        end
        else
        begin
            max_sideways_reg <= max_sideways_next;
            max_forward_reg  <= max_forward_next;
            max_wheel_reg    <= max_wheel_next;
            arm_length_reg   <= arm_length_next;
        end
    end

    // Every request is taken on the cycle it arrives.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: clamp sideways and forward to +/- their limits
    // ------------------------------------------------------------------
    logic                 s1_vld_reg, s1_vld_next;
    logic signed [FW-1:0] s1_side_reg, s1_side_next;
    logic signed [FW-1:0] s1_fwd_reg,  s1_fwd_next;
    logic signed [FW-1:0] s1_turn_reg, s1_turn_next;

    always_comb
    begin
        logic signed [FW:0] vs, vf, ls, lf;
        vs = {request.sideways_request[FW-1], request.sideways_request};
        vf = {request.forward_request[FW-1], request.forward_request};
        ls = $signed({{(FW+1-SW){1'b0}}, max_sideways_reg});
        lf = $signed({{(FW+1-SW){1'b0}}, max_forward_reg});

        s1_vld_next = start;
        if (vs > ls)
            s1_side_next = ls[FW-1:0];
        else if (vs < -ls)
            s1_side_next = FW'(-ls);
        else
            s1_side_next = request.sideways_request;

        if (vf > lf)
            s1_fwd_next = lf[FW-1:0];
        else if (vf < -lf)
            s1_fwd_next = FW'(-lf);
        else
            s1_fwd_next = request.forward_request;

        s1_turn_next = request.turn_request;
    end

    // ------------------------------------------------------------------
    // Stage 2: multiply by 1/sqrt2 (Q30) and turn rate by arm length,
    // keep the floored high parts
    // ------------------------------------------------------------------
    logic                 s2_vld_reg, s2_vld_next;
    logic signed [FW-1:0] s2_side_reg, s2_side_next;
    logic signed [FW-1:0] s2_fwd_reg,  s2_fwd_next;
    logic signed [TW-1:0] s2_turn_reg, s2_turn_next;

    always_comb
    begin
        logic signed [CPW-1:0] ps, pf;
        logic signed [TPW-1:0] pt;
        ps = CPW'(s1_side_reg) * CPW'($signed({1'b0, o4wsm_pkg::INV_SQRT2_Q30}));
        pf = CPW'(s1_fwd_reg)  * CPW'($signed({1'b0, o4wsm_pkg::INV_SQRT2_Q30}));
        pt = TPW'(s1_turn_reg) * TPW'($signed({1'b0, arm_length_reg}));

        s2_vld_next  = s1_vld_reg;
        // |v / sqrt2| stays well inside the field width
        s2_side_next = ps[FW+CSH-1:CSH];
        s2_fwd_next  = pf[FW+CSH-1:CSH];
        s2_turn_next = pt[TPW-1:FRACTION_BITS];
    end

    // ------------------------------------------------------------------
    // Stage 3: form the four wheel sums
    // ------------------------------------------------------------------
    logic                 s3_vld_reg, s3_vld_next;
    logic signed [WW-1:0] s3_whl_reg [4];
    logic signed [WW-1:0] s3_whl_next [4];

    always_comb
    begin
        logic signed [WW-1:0] xs, xf, xt;
        xs = WW'(s2_side_reg);
        xf = WW'(s2_fwd_reg);
        xt = WW'(s2_turn_reg);

        s3_vld_next    = s2_vld_reg;
        s3_whl_next[0] =  xs - xf - xt;
        s3_whl_next[1] =  xs + xf - xt;
        s3_whl_next[2] = -xs + xf - xt;
        s3_whl_next[3] = -xs - xf - xt;
    end

    // ------------------------------------------------------------------
    // Stage 4 (divider slot 0): magnitudes, peak, overflow flag, and the
    // divider's starting remainder (the limit, which is below the peak
    // whenever scaling applies)
    // Slots 1..DIV_STEPS: one restoring division step each
    // ------------------------------------------------------------------
    logic                 dv_vld_reg    [DIV_STEPS+1];
    logic                 dv_vld_next   [DIV_STEPS+1];
    logic                 dv_scl_reg    [DIV_STEPS+1];
    logic                 dv_scl_next   [DIV_STEPS+1];
    logic [WW-1:0]        dv_peak_reg   [DIV_STEPS+1];
    logic [WW-1:0]        dv_peak_next  [DIV_STEPS+1];
    logic [WW-1:0]        dv_rem_reg    [DIV_STEPS+1];
    logic [WW-1:0]        dv_rem_next   [DIV_STEPS+1];
    logic [KB-1:0]        dv_quo_reg    [DIV_STEPS+1];
    logic [KB-1:0]        dv_quo_next   [DIV_STEPS+1];
    logic signed [WW-1:0] dv_whl_reg    [DIV_STEPS+1][4];
    logic signed [WW-1:0] dv_whl_next   [DIV_STEPS+1][4];

    always_comb
    begin
        logic [WW-1:0] mag [4];
        logic [WW-1:0] pk01, pk23, pk;
        logic [WW:0]   rs, dif;

        for (int i = 0; i < 4; i++)
        begin
            mag[i] = s3_whl_reg[i][WW-1] ? WW'(-s3_whl_reg[i]) : WW'(s3_whl_reg[i]);
        end
        pk01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
        pk23 = (mag[2] > mag[3]) ? mag[2] : mag[3];
        pk   = (pk01 > pk23) ? pk01 : pk23;

        dv_vld_next[0]  = s3_vld_reg;
        dv_peak_next[0] = pk;
        dv_scl_next[0]  = pk > {{(WW-SW){1'b0}}, max_wheel_reg};
        dv_rem_next[0]  = {{(WW-SW){1'b0}}, max_wheel_reg};
        dv_quo_next[0]  = '0;
        for (int i = 0; i < 4; i++)
        begin
            dv_whl_next[0][i] = s3_whl_reg[i];
        end

        for (int j = 1; j <= DIV_STEPS; j++)
        begin
            // bring down a zero and try to subtract the peak
            rs  = {dv_rem_reg[j-1], 1'b0};
            dif = rs - {1'b0, dv_peak_reg[j-1]};
            if (rs >= {1'b0, dv_peak_reg[j-1]})
            begin
                dv_rem_next[j] = dif[WW-1:0];
                dv_quo_next[j] = {dv_quo_reg[j-1][KB-2:0], 1'b1};
            end
            else
            begin
                dv_rem_next[j] = rs[WW-1:0];
                dv_quo_next[j] = {dv_quo_reg[j-1][KB-2:0], 1'b0};
            end
            dv_vld_next[j]  = dv_vld_reg[j-1];
            dv_scl_next[j]  = dv_scl_reg[j-1];
            dv_peak_next[j] = dv_peak_reg[j-1];
            for (int i = 0; i < 4; i++)
            begin
                dv_whl_next[j][i] = dv_whl_reg[j-1][i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Scaling product: wheel times k
    // ------------------------------------------------------------------
    logic                 mu_vld_reg, mu_vld_next;
    logic                 mu_scl_reg, mu_scl_next;
    logic signed [PW-1:0] mu_prod_reg [4];
    logic signed [PW-1:0] mu_prod_next [4];
    logic signed [WW-1:0] mu_whl_reg [4];
    logic signed [WW-1:0] mu_whl_next [4];

    always_comb
    begin
        mu_vld_next = dv_vld_reg[DIV_STEPS];
        mu_scl_next = dv_scl_reg[DIV_STEPS];
        for (int i = 0; i < 4; i++)
        begin
            mu_prod_next[i] = PW'(dv_whl_reg[DIV_STEPS][i])
                              * PW'($signed({1'b0, dv_quo_reg[DIV_STEPS]}));
            mu_whl_next[i]  = dv_whl_reg[DIV_STEPS][i];
        end
    end

    // ------------------------------------------------------------------
    // Output stage: floor shift, pick scaled or plain, saturate
    // ------------------------------------------------------------------
    logic                 out_vld_reg, out_vld_next;
    o4wsm_pkg::result_t   out_res_reg, out_res_next;

    always_comb
    begin
        logic signed [WW:0]   val [4];
        logic signed [FW-1:0] sat [4];

        for (int i = 0; i < 4; i++)
        begin
            if (mu_scl_reg)
                val[i] = mu_prod_reg[i][PW-1:KB];
            else
                val[i] = {mu_whl_reg[i][WW-1], mu_whl_reg[i]};

            if (val[i] > SAT_HI)
                sat[i] = SAT_HI[FW-1:0];
            else if (val[i] < SAT_LO)
                sat[i] = SAT_LO[FW-1:0];
            else
                sat[i] = val[i][FW-1:0];
        end

        out_vld_next               = mu_vld_reg;
        out_res_next.wheel_a_speed = sat[0];
        out_res_next.wheel_b_speed = sat[1];
        out_res_next.wheel_c_speed = sat[2];
        out_res_next.wheel_d_speed = sat[3];
        out_res_next.was_scaled    = mu_scl_reg;
    end

    assign done   = out_vld_reg;
    assign result = out_res_reg;

    // ------------------------------------------------------------------
    // Pipeline registers: valid bits cleared by reset, payload free-running
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            for (int j = 0; j <= DIV_STEPS; j++)
            begin
                dv_vld_reg[j] <= 1'b0;
            end
            mu_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            s2_vld_reg  <= s2_vld_next;
            s3_vld_reg  <= s3_vld_next;
            for (int j = 0; j <= DIV_STEPS; j++)
            begin
                dv_vld_reg[j] <= dv_vld_next[j];
            end
            mu_vld_reg  <= mu_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_side_reg <= s1_side_next;
        s1_fwd_reg  <= s1_fwd_next;
        s1_turn_reg <= s1_turn_next;
        s2_side_reg <= s2_side_next;
        s2_fwd_reg  <= s2_fwd_next;
        s2_turn_reg <= s2_turn_next;
        for (int i = 0; i < 4; i++)
        begin
            s3_whl_reg[i]  <= s3_whl_next[i];
            mu_prod_reg[i] <= mu_prod_next[i];
            mu_whl_reg[i]  <= mu_whl_next[i];
        end
        for (int j = 0; j <= DIV_STEPS; j++)
        begin
            dv_scl_reg[j]  <= dv_scl_next[j];
            dv_peak_reg[j] <= dv_peak_next[j];
            dv_rem_reg[j]  <= dv_rem_next[j];
            dv_quo_reg[j]  <= dv_quo_next[j];
            for (int i = 0; i < 4; i++)
            begin
                dv_whl_reg[j][i] <= dv_whl_next[j][i];
            end
        end
        mu_scl_reg  <= mu_scl_next;
        out_res_reg <= out_res_next;
    end

endmodule
